FILE: src/pls_pkg.sv
// Shared field widths, operation codes and status codes for the positional list store.
package pls_pkg;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int NUM_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int READ_W   = 32;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] FN_READ       = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd2;
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd4;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd5;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

endpackage

FILE: src/positional_list_store.sv
// Positional list store: ordered element list in one memory with read, insert, erase, push and pop.
//
// Usage: drive req_func, req_pos, req_num and req_value with start high; the request is
// taken at a clock edge where start is high and busy is low. Exactly one response per
// request appears on rsp_status, rsp_read_value and rsp_count for one cycle, marked by
// rsp_valid. The receiver cannot stall it, so it must take every response as it comes.
// Steps from the accepting edge to the response cycle:
//   read that hits                     : memory read, then response register
//   insert or push moving k elements   : shift, drain, fill, response (k = count - position)
//   erase or pop front moving k        : shift, drain, response (k = count - position - num)
//   rejected requests, pop back, erase or pop front with nothing to move: response register
// Element moves go through the single memory read port, one element per cycle; an insert
// or push with nothing to move goes straight to fill. busy stays high from the accepting
// edge until the response cycle; a new request may be taken in the response cycle itself.
// Reset clears the element count, the sequencer and the response strobe; memory contents
// are left as they are and are never read before being written.
module positional_list_store #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pls_pkg::FUNC_W-1:0]    req_func,
   input  logic [pls_pkg::POS_W-1:0]     req_pos,
   input  logic [pls_pkg::NUM_W-1:0]     req_num,
   input  logic [pls_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [pls_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pls_pkg::READ_W-1:0]    rsp_read_value,
   output logic [pls_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > 8) ? CW : 8;

   typedef enum logic [2:0] {
      IDLE,
      RD_WAIT,
      SHIFT,
      DRAIN,
      FILL
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           cur_ff, cur_in;
   logic [AW-1:0]           end_ff, end_in;
   logic                    up_ff, up_in;
   logic [AW-1:0]           dist_ff, dist_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [ELEM_WIDTH-1:0]   val_ff, val_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           wr_ff, wr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pls_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [pls_pkg::READ_W-1:0] rsp_read_value_ff, rsp_read_value_in;

   logic [ELEM_WIDTH-1:0]   mem [CAPACITY];
   logic [ELEM_WIDTH-1:0]   rdata_ff;
   logic [AW-1:0]           rd_addr;
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [ELEM_WIDTH-1:0]   mem_wd;

   logic [SW-1:0]           c_w;
   logic [SW-1:0]           p_w;
   logic [SW-1:0]           n_w;
   logic [SW-1:0]           ins_w;
   logic [SW-1:0]           ep_w;
   logic [SW-1:0]           en_w;
   logic [SW-1:0]           eend_w;
   logic                    full;
   logic                    empty;

   assign c_w    = SW'(count_ff);
   assign p_w    = SW'(req_pos);
   assign n_w    = SW'(req_num);
   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign ins_w  = (req_func == pls_pkg::FN_INSERT)    ? p_w :
                   (req_func == pls_pkg::FN_PUSH_BACK) ? c_w : '0;
   assign ep_w   = (req_func == pls_pkg::FN_ERASE) ? p_w : '0;
   assign en_w   = (req_func == pls_pkg::FN_ERASE) ? n_w : SW'(1);
   assign eend_w = ep_w + en_w;

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      cur_in            = cur_ff;
      end_in            = end_ff;
      up_in             = up_ff;
      dist_in           = dist_ff;
      pos_in            = pos_ff;
      val_in            = val_ff;
      pend_in           = 1'b0;
      wr_in             = wr_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rd_addr           = cur_ff;
      unique case (state_ff)
         IDLE: begin
            rd_addr = AW'(req_pos);
            if (start) begin
               rsp_status_in     = pls_pkg::ST_OK;
               rsp_read_value_in = '0;
               unique case (req_func)
                  pls_pkg::FN_READ: begin
                     if (p_w < c_w) begin
                        state_in = RD_WAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pls_pkg::ST_BADPOS;
                     end
                  end
                  pls_pkg::FN_INSERT, pls_pkg::FN_PUSH_BACK, pls_pkg::FN_PUSH_FRONT: begin
                     if (req_func == pls_pkg::FN_INSERT && p_w > c_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pls_pkg::ST_BADPOS;
                     end else if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pls_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        pos_in   = AW'(ins_w);
                        val_in   = ELEM_WIDTH'(req_value);
                        if (c_w > ins_w) begin
                           cur_in   = AW'(c_w - SW'(1));
                           end_in   = AW'(ins_w);
                           up_in    = 1'b1;
                           state_in = SHIFT;
                        end else begin
                           state_in = FILL;
                        end
                     end
                  end
                  pls_pkg::FN_ERASE, pls_pkg::FN_POP_FRONT: begin
                     if (req_func == pls_pkg::FN_POP_FRONT && empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pls_pkg::ST_EMPTY;
                     end else if (eend_w > c_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pls_pkg::ST_BADPOS;
                     end else begin
                        count_in = CW'(c_w - en_w);
                        if (en_w != '0 && eend_w < c_w) begin
                           cur_in   = AW'(eend_w);
                           end_in   = AW'(c_w - SW'(1));
                           up_in    = 1'b0;
                           dist_in  = AW'(en_w);
                           state_in = SHIFT;
                        end else begin
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  pls_pkg::FN_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = pls_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         RD_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = pls_pkg::READ_W'(rdata_ff);
            state_in          = IDLE;
         end
         SHIFT: begin
            pend_in = 1'b1;
            wr_in   = up_ff ? (cur_ff + AW'(1)) : (cur_ff - dist_ff);
            if (cur_ff == end_ff) begin
               state_in = DRAIN;
            end else begin
               cur_in = up_ff ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
            end
         end
         DRAIN: begin
            if (up_ff) begin
               state_in = FILL;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         FILL: begin
            rsp_valid_in = 1'b1;
            state_in     = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff            <= cur_in;
      end_ff            <= end_in;
      up_ff             <= up_in;
      dist_ff           <= dist_in;
      pos_ff            <= pos_in;
      val_ff            <= val_in;
      wr_ff             <= wr_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   assign mem_we = pend_ff || (state_ff == FILL);
   assign mem_wa = pend_ff ? wr_ff : pos_ff;
   assign mem_wd = pend_ff ? rdata_ff : val_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign busy           = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = pls_pkg::COUNT_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("response issued while still busy");

   a_fill_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FILL) |-> !pend_ff)
      else $error("fill write collides with pending shift write");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RD_WAIT) |=> (rsp_valid_ff && rsp_status_ff == pls_pkg::ST_OK))
      else $error("read response missing");
`endif

endmodule
